/* src/cspk_pkg.sv */
package cspk_pkg;

    // Item kinds carried on the input tuser
    localparam logic KIND_BOOT = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    // Boot sources
    localparam logic [1:0] SRC_LONG_PRESS  = 2'd1;
    localparam logic [1:0] SRC_SHORT_PRESS = 2'd2;

    // Logo indexes
    localparam logic [3:0] LOGO_NONE = 4'd0;
    localparam logic [3:0] LOGO_TOP  = 4'd10;
    localparam logic [3:0] LOGO_FULL = 4'd11;
    localparam logic [3:0] LOGO_FAIL = 4'd12;
    localparam logic [3:0] LOGO_LOW  = 4'd13;

    localparam logic [6:0] CAP_FULL     = 7'd100;
    localparam logic [7:0] HOLD_SAT     = 8'd255;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_THRESHOLD    = 3'd0;
    localparam logic [2:0] REG_FAIL_VOLTAGE = 3'd1;
    localparam logic [2:0] REG_POWEROFF     = 3'd2;
    localparam logic [2:0] REG_HOLD         = 3'd3;
    localparam logic [2:0] REG_REFRESH      = 3'd4;

    // Register reset values
    localparam logic [6:0]  RST_THRESHOLD    = 7'd0;
    localparam logic [22:0] RST_FAIL_VOLTAGE = 23'd2000000;
    localparam logic [10:0] RST_POWEROFF     = 11'd1500;
    localparam logic [7:0]  RST_HOLD         = 8'd200;
    localparam logic [5:0]  RST_REFRESH      = 6'd50;

    typedef enum logic [1:0] {
        MODE_CONTINUE = 2'd0,
        MODE_CHARGING = 2'd1,
        MODE_LOW      = 2'd2,
        MODE_FAIL     = 2'd3
    } mode_t;

    typedef struct packed {
        logic [6:0]  power_on_threshold;
        logic [22:0] fail_voltage_uv;
        logic [10:0] poweroff_ticks;
        logic [7:0]  poweron_hold_ticks;
        logic [5:0]  refresh_period;
    } cfg_t;

    typedef struct packed {
        logic        power_key;
        logic [22:0] battery_voltage_uv;
        logic [6:0]  battery_capacity;
        logic        charger_online;
        logic        skip_boot_check;
        logic [1:0]  wake_source;
        logic        kind;
    } item_t;

    typedef struct packed {
        logic       power_on;
        logic       power_off;
        logic [3:0] logo_index;
        logic       show_logo;
        logic [1:0] mode;
    } result_t;

    // Capacity percent to animation frame: tens digit, full at 100 and above
    function automatic logic [3:0] cap_index(input logic [6:0] cap);
        logic [3:0] idx;
        idx = 4'd0;
        for (int i = 1; i <= 10; i++) begin
            if (cap >= 7'(10 * i))
            begin
                idx = 4'(i);
            end
        end
        if (cap >= CAP_FULL)
        begin
            idx = LOGO_FULL;
        end
        return idx;
    endfunction

endpackage

/* src/charge_screen_power_key_controller.sv */
// Boot-time charge screen and power key controller. A boot beat (tuser 0)
// picks the mode (continue, charging, low battery, battery fail) from the
// boot source, recovery/reboot flag, charger presence, capacity against
// power_on_threshold and voltage against fail_voltage_uv; it may show a
// fixed logo, start the charging animation or order power off. Tick beats
// (tuser 1, every 10 ms) step the animation each refresh_period, count down
// poweroff_ticks and time the power key: holding it past poweron_hold_ticks
// orders power on, releasing it early orders power off. After power off or
// power on the block is halted and answers every beat with the last mode
// and all other fields zero until reset. Every input beat gives exactly one
// result beat. One beat is accepted per clock while the result side does not
// stall; its result beat is presented after the input register and then the
// state update into the result register, and a stalled result holds the input.
// Registers sit at byte addresses 0x00 threshold, 0x04 fail voltage, 0x08
// power-off ticks, 0x0C hold ticks, 0x10 refresh period, and should be
// written only while no beat is in flight.
module charge_screen_power_key_controller
    import cspk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // wake_source[1:0], skip_boot_check[2], charger_online[3],
    // battery_capacity[10:4], battery_voltage_uv[33:11], power_key[34]
    input  logic [39:0] s_tdata,
    // kind[0]
    input  logic        s_tuser,
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // mode[1:0], show_logo[2], logo_index[6:3], power_off[7], power_on[8]
    output logic [15:0] m_tdata
);

    cfg_t    cfg;
    item_t   in_item;
    result_t out_result;

    // Unpack the input beat
    always_comb
    begin
        in_item.kind               = s_tuser;
        in_item.wake_source        = s_tdata[1:0];
        in_item.skip_boot_check    = s_tdata[2];
        in_item.charger_online     = s_tdata[3];
        in_item.battery_capacity   = s_tdata[10:4];
        in_item.battery_voltage_uv = s_tdata[33:11];
        in_item.power_key          = s_tdata[34];
    end

    // Pack the result beat
    assign m_tdata = {7'd0, out_result.power_on, out_result.power_off,
                      out_result.logo_index, out_result.show_logo, out_result.mode};

    cspk_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cspk_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_result (out_result)
    );

endmodule

/* src/cspk_regs.sv */
module cspk_regs
    import cspk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign cfg     = cfg_reg;

    // Write a register on the access beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.power_on_threshold <= RST_THRESHOLD;
            cfg_reg.fail_voltage_uv    <= RST_FAIL_VOLTAGE;
            cfg_reg.poweroff_ticks     <= RST_POWEROFF;
            cfg_reg.poweron_hold_ticks <= RST_HOLD;
            cfg_reg.refresh_period     <= RST_REFRESH;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_THRESHOLD:    cfg_reg.power_on_threshold <= pwdata[6:0];
                REG_FAIL_VOLTAGE: cfg_reg.fail_voltage_uv    <= pwdata[22:0];
                REG_POWEROFF:     cfg_reg.poweroff_ticks     <= pwdata[10:0];
                REG_HOLD:         cfg_reg.poweron_hold_ticks <= pwdata[7:0];
                REG_REFRESH:      cfg_reg.refresh_period     <= pwdata[5:0];
                default:          ;
            endcase
        end
    end

    // Read back the selected register
    always_comb
    begin
        unique case (reg_sel)
            REG_THRESHOLD:    prdata = {25'd0, cfg_reg.power_on_threshold};
            REG_FAIL_VOLTAGE: prdata = {9'd0, cfg_reg.fail_voltage_uv};
            REG_POWEROFF:     prdata = {21'd0, cfg_reg.poweroff_ticks};
            REG_HOLD:         prdata = {24'd0, cfg_reg.poweron_hold_ticks};
            REG_REFRESH:      prdata = {26'd0, cfg_reg.refresh_period};
            default:          prdata = 32'd0;
        endcase
    end

endmodule

/* src/cspk_core.sv */
module cspk_core
    import cspk_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_result
);

    // Pipeline registers
    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_valid_reg;
    result_t result_reg;

    // Controller state
    mode_t       mode_reg, mode_next;
    logic        animating_reg, animating_next;
    logic        halted_reg, halted_next;
    logic [3:0]  anim_reg, anim_next;
    logic [5:0]  refresh_reg, refresh_next;
    logic [10:0] countdown_reg, countdown_next;
    logic        armed_reg, armed_next;
    logic [7:0]  hold_reg, hold_next;

    logic        load_out;
    logic        advance;
    logic        stop;
    logic        show;
    logic [3:0]  logo;
    logic        poff;
    logic        pon;
    logic [10:0] countdown_dec;
    logic [6:0]  refresh_inc;
    logic [3:0]  anim_inc;
    logic [7:0]  hold_inc;
    logic [3:0]  cap_idx;
    result_t     result_next;

    assign load_out   = !out_valid_reg || out_ready;
    assign advance    = in_valid_reg && load_out;
    assign in_ready   = !in_valid_reg || load_out;
    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    // Controller state, updated as each item passes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_CONTINUE;
            animating_reg <= 1'b0;
            halted_reg    <= 1'b0;
            anim_reg      <= 4'd0;
            refresh_reg   <= 6'd0;
            countdown_reg <= 11'd0;
            armed_reg     <= 1'b0;
            hold_reg      <= 8'd0;
        end
        else if (advance)
        begin
            mode_reg      <= mode_next;
            animating_reg <= animating_next;
            halted_reg    <= halted_next;
            anim_reg      <= anim_next;
            refresh_reg   <= refresh_next;
            countdown_reg <= countdown_next;
            armed_reg     <= armed_next;
            hold_reg      <= hold_next;
        end
    end

    assign countdown_dec = countdown_reg - 11'd1;
    assign refresh_inc   = {1'b0, refresh_reg} + 7'd1;
    assign anim_inc      = anim_reg + 4'd1;
    assign hold_inc      = (hold_reg != HOLD_SAT) ? hold_reg + 8'd1 : hold_reg;
    assign cap_idx       = cap_index(item_reg.battery_capacity);

    // Boot decision and tick handling
    always_comb
    begin
        mode_next      = mode_reg;
        animating_next = animating_reg;
        halted_next    = halted_reg;
        anim_next      = anim_reg;
        refresh_next   = refresh_reg;
        countdown_next = countdown_reg;
        armed_next     = armed_reg;
        hold_next      = hold_reg;
        stop = 1'b0;
        show = 1'b0;
        logo = LOGO_NONE;
        poff = 1'b0;
        pon  = 1'b0;

        if (halted_reg)
        begin
            // ignore everything once halted
        end
        else if (item_reg.kind == KIND_BOOT)
        begin
            animating_next = 1'b0;
            mode_next      = MODE_CONTINUE;
            if (!item_reg.skip_boot_check)
            begin
                if (item_reg.charger_online)
                begin
                    if (item_reg.wake_source == SRC_LONG_PRESS)
                    begin
                        if (item_reg.battery_capacity < cfg.power_on_threshold &&
                            item_reg.battery_voltage_uv > cfg.fail_voltage_uv)
                        begin
                            mode_next      = MODE_CHARGING;
                            animating_next = 1'b1;
                            anim_next      = cap_idx;
                            refresh_next   = 6'd0;
                            countdown_next = cfg.poweroff_ticks;
                            armed_next     = 1'b0;
                            hold_next      = 8'd0;
                        end
                    end
                    else if (item_reg.wake_source == SRC_SHORT_PRESS)
                    begin
                        anim_next      = cap_idx;
                        refresh_next   = 6'd0;
                        countdown_next = cfg.poweroff_ticks;
                        armed_next     = 1'b0;
                        hold_next      = 8'd0;
                        if (item_reg.battery_voltage_uv < cfg.fail_voltage_uv)
                        begin
                            mode_next = MODE_FAIL;
                            show      = 1'b1;
                            logo      = LOGO_FAIL;
                        end
                        else
                        begin
                            mode_next      = MODE_CHARGING;
                            animating_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (item_reg.wake_source == SRC_LONG_PRESS)
                    begin
                        if (item_reg.battery_capacity < cfg.power_on_threshold)
                        begin
                            mode_next      = MODE_LOW;
                            anim_next      = cap_idx;
                            refresh_next   = 6'd0;
                            countdown_next = cfg.poweroff_ticks;
                            armed_next     = 1'b0;
                            hold_next      = 8'd0;
                            show           = 1'b1;
                            logo           = LOGO_LOW;
                        end
                    end
                    else if (item_reg.wake_source == SRC_SHORT_PRESS)
                    begin
                        poff        = 1'b1;
                        halted_next = 1'b1;
                    end
                end
            end
        end
        else if (animating_reg)
        begin
            // countdown expiry wins over everything on this tick
            countdown_next = countdown_dec;
            if (countdown_dec == 11'd0)
            begin
                poff = 1'b1;
                stop = 1'b1;
            end
            else if (refresh_reg == 6'd0)
            begin
                if (!item_reg.charger_online)
                begin
                    poff = 1'b1;
                    stop = 1'b1;
                end
                else
                begin
                    show = 1'b1;
                    logo = anim_reg;
                    if (anim_reg != LOGO_FULL)
                    begin
                        anim_next = (anim_inc > LOGO_TOP) ? cap_idx : anim_inc;
                    end
                end
            end

            // advance refresh and time the power key
            if (!stop)
            begin
                refresh_next = (refresh_inc > {1'b0, cfg.refresh_period}) ?
                               6'd0 : refresh_inc[5:0];
                if (armed_reg)
                begin
                    if (item_reg.power_key)
                    begin
                        hold_next = hold_inc;
                        if (hold_inc > cfg.poweron_hold_ticks)
                        begin
                            pon  = 1'b1;
                            stop = 1'b1;
                        end
                    end
                    else
                    begin
                        poff = 1'b1;
                        stop = 1'b1;
                    end
                end
                else if (item_reg.power_key)
                begin
                    countdown_next = cfg.poweroff_ticks;
                    armed_next     = 1'b1;
                    hold_next      = 8'd0;
                end
            end

            if (stop)
            begin
                halted_next    = 1'b1;
                animating_next = 1'b0;
            end
        end
    end

    // Assemble the result beat
    always_comb
    begin
        result_next.mode       = mode_next;
        result_next.show_logo  = show;
        result_next.logo_index = logo;
        result_next.power_off  = poff;
        result_next.power_on   = pon;
    end

endmodule

/* src/cspk_checker.sv */
module cspk_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata
);

    logic halted_seen_reg;
    logic halted_seen_next;
    logic out_beat;

    assign out_beat         = m_tvalid && m_tready;
    assign halted_seen_next = halted_seen_reg || (out_beat && (m_tdata[7] || m_tdata[8]));

    // Remember that a power off or power on beat went out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            halted_seen_reg <= 1'b0;
        end
        else
        begin
            halted_seen_reg <= halted_seen_next;
        end
    end

    // Stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // No logo index without a logo
    a_logo_gated: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[2] |-> m_tdata[6:3] == 4'd0)
        else $error("logo index set while no logo shown");

    // Power off and power on never ordered together
    a_power_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[7] && m_tdata[8]))
        else $error("power off and power on in one beat");

    // Once halted, results carry only the mode
    a_halted_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && halted_seen_reg |-> m_tdata[8:2] == 7'd0)
        else $error("activity after power off or power on");

endmodule

bind charge_screen_power_key_controller cspk_checker u_cspk_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import cspk_pkg::*;

    localparam logic [1:0]  SRC_NONE  = 2'd0;
    localparam logic [1:0]  SRC_OTHER = 2'd3;
    localparam logic [22:0] VOLT_MAX  = 23'd8000000;
    localparam int          LONG_HOLD = 300;
    localparam int          SETTLE    = 4;

    typedef enum int {
        HALT_NO_CHARGER,
        HALT_COUNTDOWN,
        HALT_CHARGER_LOST,
        HALT_KEY_RELEASE,
        HALT_KEY_HOLD
    } halt_cause_t;

    // Predicted controller state
    typedef struct packed {
        mode_t       mode;
        logic        animating;
        logic        halted;
        logic [3:0]  frame;
        logic [5:0]  refresh;
        logic [10:0] countdown;
        logic        armed;
        logic [7:0]  hold;
    } screen_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;

    cfg_t        cfg;
    screen_t     scr;
    result_t     results_due[$];
    int          mismatch_count = 0;
    int          send_idle = 0;
    int          stall_pct = 0;
    logic        key_level = 1'b0;
    logic        hold_req = 1'b0;
    logic        hold_seen = 1'b0;
    int          hold_left = 0;
    result_t     want_beat;
    result_t     seen_beat;

    charge_screen_power_key_controller dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    // Capacity percent to animation frame
    function automatic logic [3:0] frame_for(input logic [6:0] cap);
        return (cap >= CAP_FULL) ? LOGO_FULL : 4'(cap / 7'd10);
    endfunction

    // Load the charge screen counters for a new mode
    function automatic void open_screen(inout screen_t s, input logic [6:0] cap);
        s.frame     = frame_for(cap);
        s.refresh   = '0;
        s.countdown = cfg.poweroff_ticks;
        s.armed     = 1'b0;
        s.hold      = '0;
    endfunction

    // Work out the result beat of one item and advance the state
    function automatic result_t charge_step(input item_t it, inout screen_t s);
        result_t    r;
        logic       stop;
        logic [6:0] nxt;
        r = '0;
        stop = 1'b0;
        if (s.halted)
        begin
            // ignored
        end
        else if (it.kind == KIND_BOOT)
        begin
            s.animating = 1'b0;
            s.mode = MODE_CONTINUE;
            if (!it.skip_boot_check)
            begin
                if (it.charger_online)
                begin
                    if (it.wake_source == SRC_LONG_PRESS)
                    begin
                        if (it.battery_capacity < cfg.power_on_threshold &&
                            it.battery_voltage_uv > cfg.fail_voltage_uv)
                        begin
                            s.mode = MODE_CHARGING;
                            open_screen(s, it.battery_capacity);
                            s.animating = 1'b1;
                        end
                    end
                    else if (it.wake_source == SRC_SHORT_PRESS)
                    begin
                        open_screen(s, it.battery_capacity);
                        if (it.battery_voltage_uv < cfg.fail_voltage_uv)
                        begin
                            s.mode = MODE_FAIL;
                            r.show_logo = 1'b1;
                            r.logo_index = LOGO_FAIL;
                        end
                        else
                        begin
                            s.mode = MODE_CHARGING;
                            s.animating = 1'b1;
                        end
                    end
                end
                else
                begin
                    if (it.wake_source == SRC_LONG_PRESS)
                    begin
                        if (it.battery_capacity < cfg.power_on_threshold)
                        begin
                            s.mode = MODE_LOW;
                            open_screen(s, it.battery_capacity);
                            r.show_logo = 1'b1;
                            r.logo_index = LOGO_LOW;
                        end
                    end
                    else if (it.wake_source == SRC_SHORT_PRESS)
                    begin
                        r.power_off = 1'b1;
                        s.halted = 1'b1;
                    end
                end
            end
        end
        else if (s.animating)
        begin
            // count down to automatic power off
            s.countdown = s.countdown - 11'd1;
            if (s.countdown == '0)
            begin
                r.power_off = 1'b1;
                stop = 1'b1;
            end
            // refresh the display, drop out if the charger went away
            if (!stop && s.refresh == '0)
            begin
                if (!it.charger_online)
                begin
                    r.power_off = 1'b1;
                    stop = 1'b1;
                end
                else
                begin
                    r.show_logo = 1'b1;
                    r.logo_index = s.frame;
                    if (s.frame != LOGO_FULL)
                    begin
                        s.frame = s.frame + 4'd1;
                        if (s.frame > LOGO_TOP)
                        begin
                            s.frame = frame_for(it.battery_capacity);
                        end
                    end
                end
            end
            // advance refresh counter and time the power key
            if (!stop)
            begin
                nxt = {1'b0, s.refresh} + 7'd1;
                s.refresh = (nxt > {1'b0, cfg.refresh_period}) ? 6'd0 : nxt[5:0];
                if (s.armed)
                begin
                    if (it.power_key)
                    begin
                        if (s.hold != HOLD_SAT)
                        begin
                            s.hold = s.hold + 8'd1;
                        end
                        if (s.hold > cfg.poweron_hold_ticks)
                        begin
                            r.power_on = 1'b1;
                            stop = 1'b1;
                        end
                    end
                    else
                    begin
                        r.power_off = 1'b1;
                        stop = 1'b1;
                    end
                end
                else if (it.power_key)
                begin
                    s.countdown = cfg.poweroff_ticks;
                    s.armed = 1'b1;
                    s.hold = '0;
                end
            end
            if (stop)
            begin
                s.halted = 1'b1;
                s.animating = 1'b0;
            end
        end
        r.mode = s.mode;
        return r;
    endfunction

    function automatic logic would_halt(input item_t it);
        screen_t probe;
        probe = scr;
        void'(charge_step(it, probe));
        return probe.halted;
    endfunction

    function automatic item_t make_item(input logic kind, input logic [1:0] src,
                                        input logic skip, input logic online,
                                        input logic [6:0] cap, input logic [22:0] volt,
                                        input logic key);
        item_t it;
        it.kind               = kind;
        it.wake_source        = src;
        it.skip_boot_check    = skip;
        it.charger_online     = online;
        it.battery_capacity   = cap;
        it.battery_voltage_uv = volt;
        it.power_key          = key;
        return it;
    endfunction

    // Mostly ticks on a running animation with a slowly moving key
    function automatic item_t random_item();
        item_t it;
        int    pick;
        it.kind = ($urandom_range(99) < (scr.animating ? 12 : 60)) ? KIND_BOOT : KIND_TICK;
        pick = $urandom_range(9);
        it.wake_source = (pick < 4) ? SRC_LONG_PRESS :
                         (pick < 8) ? SRC_SHORT_PRESS : 2'($urandom_range(3));
        it.skip_boot_check = ($urandom_range(9) == 0);
        it.charger_online = ($urandom_range(9) != 0);
        pick = $urandom_range(9);
        it.battery_capacity = (pick == 0) ? 7'd0 :
                              (pick == 1) ? CAP_FULL : 7'($urandom_range(100));
        pick = $urandom_range(9);
        if (pick < 2)
        begin
            it.battery_voltage_uv = cfg.fail_voltage_uv + 23'(pick);
        end
        else if (pick < 5)
        begin
            it.battery_voltage_uv = 23'($urandom_range(VOLT_MAX, cfg.fail_voltage_uv));
        end
        else
        begin
            it.battery_voltage_uv = 23'($urandom_range(VOLT_MAX));
        end
        if (it.kind == KIND_TICK && $urandom_range(99) < 8)
        begin
            key_level = !key_level;
        end
        it.power_key = (it.kind == KIND_TICK) ? key_level : 1'($urandom_range(1));
        return it;
    endfunction

    // Offer one input beat, hold until accepted, queue its result
    task automatic send_beat(input item_t it);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tdata  <= {5'b0, it[35:1]};
        s_tuser  <= it.kind;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        results_due.push_back(charge_step(it, scr));
    endtask

    // Drop valid and wait until every result beat is back
    task automatic settle();
        s_tvalid <= 1'b0;
        while (results_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        unique case (idx)
            REG_THRESHOLD:    cfg.power_on_threshold = value[6:0];
            REG_FAIL_VOLTAGE: cfg.fail_voltage_uv    = value[22:0];
            REG_POWEROFF:     cfg.poweroff_ticks     = value[10:0];
            REG_HOLD:         cfg.poweron_hold_ticks = value[7:0];
            REG_REFRESH:      cfg.refresh_period     = value[5:0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int thr, input int fail, input int ticks,
                             input int hold, input int period);
        write_reg(REG_THRESHOLD, thr);
        write_reg(REG_FAIL_VOLTAGE, fail);
        write_reg(REG_POWEROFF, ticks);
        write_reg(REG_HOLD, hold);
        write_reg(REG_REFRESH, period);
    endtask

    task automatic set_pace(input int idle, input int stall);
        send_idle = idle;
        stall_pct <= stall;
    endtask

    // Send random beats, steering away from anything that would halt the block
    task automatic run_traffic(input int beats);
        item_t it;
        int    counted;
        counted = 0;
        while (counted < beats)
        begin
            it = random_item();
            if (would_halt(it))
            begin
                it.kind = KIND_BOOT;
                it.skip_boot_check = 1'b0;
                it.charger_online = 1'b1;
                it.wake_source = SRC_SHORT_PRESS;
            end
            send_beat(it);
            counted++;
        end
    endtask

    task automatic test_boot_decisions();
        settle();
        write_reg(REG_THRESHOLD, 50);
        write_reg(REG_FAIL_VOLTAGE, 3000000);
        set_pace(0, 0);
        send_beat(make_item(KIND_BOOT, SRC_LONG_PRESS, 1'b1, 1'b1, 7'd10, VOLT_MAX, 1'b0));
        send_beat(make_item(KIND_BOOT, SRC_LONG_PRESS, 1'b0, 1'b1, 7'd49, 23'd3000001, 1'b0));
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd49, 23'd3000001, 1'b0));
        // boot while animating stops the animation
        send_beat(make_item(KIND_BOOT, SRC_LONG_PRESS, 1'b0, 1'b1, 7'd50, VOLT_MAX, 1'b0));
        send_beat(make_item(KIND_BOOT, SRC_LONG_PRESS, 1'b0, 1'b1, 7'd0, 23'd3000000, 1'b1));
        send_beat(make_item(KIND_BOOT, SRC_SHORT_PRESS, 1'b0, 1'b1, CAP_FULL, 23'd2999999,
                            1'b0));
        // tick with no animation running is ignored
        send_beat(make_item(KIND_TICK, SRC_OTHER, 1'b1, 1'b1, CAP_FULL, VOLT_MAX, 1'b1));
        send_beat(make_item(KIND_BOOT, SRC_SHORT_PRESS, 1'b0, 1'b1, CAP_FULL, 23'd3000000,
                            1'b0));
        send_beat(make_item(KIND_BOOT, SRC_LONG_PRESS, 1'b0, 1'b0, 7'd49, 23'd0, 1'b0));
        send_beat(make_item(KIND_BOOT, SRC_LONG_PRESS, 1'b0, 1'b0, 7'd50, 23'd0, 1'b1));
        send_beat(make_item(KIND_BOOT, SRC_NONE, 1'b0, 1'b1, 7'd5, VOLT_MAX, 1'b0));
        send_beat(make_item(KIND_BOOT, SRC_OTHER, 1'b0, 1'b0, 7'd5, 23'd0, 1'b0));
        send_beat(make_item(KIND_BOOT, SRC_OTHER, 1'b0, 1'b1, 7'd127, VOLT_MAX, 1'b1));
    endtask

    task automatic test_animation_and_key();
        settle();
        write_all(101, 0, 2047, 254, 1);
        send_beat(make_item(KIND_BOOT, SRC_SHORT_PRESS, 1'b0, 1'b1, 7'd95, 23'd0, 1'b0));
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd95, 23'd0, 1'b0));
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd95, 23'd0, 1'b0));
        // frame wraps past the top and reloads from full capacity
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, CAP_FULL, 23'd0, 1'b0));
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b0, 7'd95, 23'd0, 1'b0));
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd95, 23'd0, 1'b0));
        // arm the key and hold it
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd95, 23'd0, 1'b1));
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd95, 23'd0, 1'b1));
        send_beat(make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd95, 23'd0, 1'b1));
        send_beat(make_item(KIND_BOOT, SRC_LONG_PRESS, 1'b0, 1'b1, CAP_FULL, 23'd1, 1'b1));
    endtask

    task automatic test_random_traffic();
        settle();
        write_all(60, 2000000, 2047, 254, 63);
        set_pace(0, 0);
        run_traffic(220);
        settle();
        write_all(0, VOLT_MAX, 300, 20, 3);
        set_pace(48, 0);
        run_traffic(220);
        settle();
        write_all(101, 0, 40, 5, 1);
        set_pace(0, 48);
        run_traffic(220);
        settle();
        write_all($urandom_range(101), $urandom_range(VOLT_MAX), $urandom_range(2047, 1),
                  $urandom_range(254, 1), $urandom_range(63, 1));
        set_pace(37, 37);
        run_traffic(240);
        settle();
        write_all(30, 1000000, 1, 1, 2);
        run_traffic(60);
    endtask

    // Stall the result side long enough for the input to back up
    task automatic test_backpressure();
        settle();
        write_all(80, 2500000, 2047, 254, 4);
        set_pace(0, 0);
        hold_req <= ~hold_req;
        run_traffic(60);
    endtask

    // Halt the block by one cause picked at random, then show it ignores beats
    task automatic test_halt_paths();
        halt_cause_t cause;
        item_t       boot_beat;
        item_t       tick_beat;
        settle();
        cause = halt_cause_t'($urandom_range(4));
        write_all(101, 1000000, (cause == HALT_COUNTDOWN) ? 1 : 2047, 1, 1);
        set_pace(37, 37);
        boot_beat = make_item(KIND_BOOT, SRC_SHORT_PRESS, 1'b0, 1'b1, 7'd55, VOLT_MAX, 1'b0);
        tick_beat = make_item(KIND_TICK, SRC_NONE, 1'b0, 1'b1, 7'd55, VOLT_MAX, 1'b0);
        if (cause == HALT_NO_CHARGER)
        begin
            send_beat(make_item(KIND_BOOT, SRC_SHORT_PRESS, 1'b0, 1'b0, 7'd55, VOLT_MAX,
                                1'b0));
        end
        else
        begin
            send_beat(boot_beat);
            tick_beat.power_key = (cause == HALT_KEY_RELEASE || cause == HALT_KEY_HOLD);
            send_beat(tick_beat);
            if (cause != HALT_COUNTDOWN)
            begin
                send_beat(tick_beat);
                // last tick lands on a refresh: lost charger, key release or hold
                tick_beat.charger_online = (cause != HALT_CHARGER_LOST);
                tick_beat.power_key = (cause == HALT_KEY_HOLD);
                send_beat(tick_beat);
            end
        end
        send_beat(boot_beat);
        tick_beat.power_key = 1'b1;
        send_beat(tick_beat);
    endtask

    // Result side ready, with random stalls and an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic void check_field(input string field, input logic [3:0] want,
                                        input logic [3:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each result beat with the oldest expected one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (results_due.size() == 0)
            begin
                $display("%0t: result beat with none expected, expected none, actual %h",
                         $time, m_tdata);
                mismatch_count++;
            end
            else
            begin
                want_beat = results_due.pop_front();
                seen_beat = m_tdata[8:0];
                check_field("mode", 4'(want_beat.mode), 4'(seen_beat.mode));
                check_field("show_logo", 4'(want_beat.show_logo), 4'(seen_beat.show_logo));
                check_field("logo_index", want_beat.logo_index, seen_beat.logo_index);
                check_field("power_off", 4'(want_beat.power_off), 4'(seen_beat.power_off));
                check_field("power_on", 4'(want_beat.power_on), 4'(seen_beat.power_on));
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        cfg = '{power_on_threshold: RST_THRESHOLD, fail_voltage_uv: RST_FAIL_VOLTAGE,
                poweroff_ticks: RST_POWEROFF, poweron_hold_ticks: RST_HOLD,
                refresh_period: RST_REFRESH};
        scr = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_boot_decisions();
        test_animation_and_key();
        test_random_traffic();
        test_backpressure();
        test_halt_paths();
        settle();
        if (mismatch_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
